### design/sliding_window_candle_aggregator_unit_assert.svh
// Assertion macros used by the candle aggregator checker.
`ifndef SLIDING_WINDOW_CANDLE_AGGREGATOR_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_CANDLE_AGGREGATOR_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define SWCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define SWCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/swca_pkg.sv
// Shared types and constants of the sliding-window candle aggregator.
package swca_pkg;

  localparam int unsigned PRICE_BITS = 32;
  localparam int unsigned WLEN_BITS  = 7;
  localparam int unsigned DAY_BITS   = 5;
  localparam int unsigned MONTH_BITS = 4;
  localparam int unsigned YEAR_BITS  = 12;

  localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd14;

  // Chain-wide control driven by the top level.
  typedef struct packed {
    logic shift;  // move every candle one cell down the chain
    logic adv;    // move the aggregate token one cell down the chain
  } swca_ctrl_t;

endpackage

### design/swca_cell.sv
// One chain cell: holds a candle and merges it into the passing aggregate token.
module swca_cell #(
  parameter int unsigned PW = 32,
  parameter int unsigned CW = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swca_pkg::swca_ctrl_t  ctrl_i,
  input  logic [PW-1:0]         opn_i,
  input  logic [PW-1:0]         hi_i,
  input  logic [PW-1:0]         lo_i,
  output logic [PW-1:0]         opn_o,
  output logic [PW-1:0]         hi_o,
  output logic [PW-1:0]         lo_o,
  input  logic                  tok_vld_i,
  input  logic [CW-1:0]         tok_rem_i,
  input  logic [PW-1:0]         tok_hi_i,
  input  logic [PW-1:0]         tok_lo_i,
  input  logic [PW-1:0]         tok_opn_i,
  output logic                  tok_vld_o,
  output logic [CW-1:0]         tok_rem_o,
  output logic [PW-1:0]         tok_hi_o,
  output logic [PW-1:0]         tok_lo_o,
  output logic [PW-1:0]         tok_opn_o
);
  import swca_pkg::*;

  logic [PW-1:0] opn_q, hi_q, lo_q;
  logic          tvld_q;
  logic [CW-1:0] trem_q, trem_d;
  logic [PW-1:0] thi_q, thi_d, tlo_q, tlo_d, topn_q, topn_d;

  // Fold this cell in while the token still has window cells to cover.
  always_comb begin
    trem_d = tok_rem_i;
    thi_d  = tok_hi_i;
    tlo_d  = tok_lo_i;
    topn_d = tok_opn_i;
    if (tok_rem_i != '0) begin
      trem_d = tok_rem_i - CW'(1);
      thi_d  = (hi_q > tok_hi_i) ? hi_q : tok_hi_i;
      tlo_d  = (lo_q < tok_lo_i) ? lo_q : tok_lo_i;
      topn_d = opn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      opn_q <= opn_i;
      hi_q  <= hi_i;
      lo_q  <= lo_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvld_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      tvld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      trem_q <= trem_d;
      thi_q  <= thi_d;
      tlo_q  <= tlo_d;
      topn_q <= topn_d;
    end
  end

  assign opn_o     = opn_q;
  assign hi_o      = hi_q;
  assign lo_o      = lo_q;
  assign tok_vld_o = tvld_q;
  assign tok_rem_o = trem_q;
  assign tok_hi_o  = thi_q;
  assign tok_lo_o  = tlo_q;
  assign tok_opn_o = topn_q;

endmodule

### design/sliding_window_candle_aggregator_unit.sv
// Sliding-window candle aggregator: each accepted candle enters a chain of
// MAX_WINDOW cells, newest at the head. Once the candle count reaches the
// window length, an aggregate token walks the whole chain one cell per
// cycle unless it is held at the tail, collecting the window high and low
// and the oldest open, and lands in the output register with the newest
// close and date. A candle that yields a result keeps the input closed
// until its token lands (the token is launched, walks the MAX_WINDOW
// cells and is dropped into the output register); a result still waiting
// in the output register when the token reaches the tail stretches this
// until that result is taken. A candle that yields none leaves the input
// open. While a finished result waits in the output register the
// next candle is still taken. No clearing pass is needed after reset.
module sliding_window_candle_aggregator_unit #(
  parameter int unsigned MAX_WINDOW  = 64,
  parameter int unsigned PRICE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swca_pkg::WLEN_BITS-1:0]      cfg_window_length_i,
  // candle input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [swca_pkg::PRICE_BITS-1:0]     open_price_i,
  input  logic [swca_pkg::PRICE_BITS-1:0]     high_price_i,
  input  logic [swca_pkg::PRICE_BITS-1:0]     low_price_i,
  input  logic [swca_pkg::PRICE_BITS-1:0]     close_price_i,
  input  logic [swca_pkg::DAY_BITS-1:0]       day_in_i,
  input  logic [swca_pkg::MONTH_BITS-1:0]     month_in_i,
  input  logic [swca_pkg::YEAR_BITS-1:0]      year_in_i,
  // aggregate output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [swca_pkg::PRICE_BITS-1:0]     agg_open_o,
  output logic [swca_pkg::PRICE_BITS-1:0]     agg_high_o,
  output logic [swca_pkg::PRICE_BITS-1:0]     agg_low_o,
  output logic [swca_pkg::PRICE_BITS-1:0]     agg_close_o,
  output logic [swca_pkg::DAY_BITS-1:0]       day_out_o,
  output logic [swca_pkg::MONTH_BITS-1:0]     month_out_o,
  output logic [swca_pkg::YEAR_BITS-1:0]      year_out_o
);
  import swca_pkg::*;

  localparam int unsigned PW = PRICE_WIDTH;
  localparam int unsigned CW = (MAX_WINDOW < 2) ? 1 : $clog2(MAX_WINDOW + 1);

  // Window length register; the port is always ready.
  logic [WLEN_BITS-1:0] wlen_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RESET;
    end else if (cfg_valid_i) begin
      wlen_q <= cfg_window_length_i;
    end
  end

  // Clamp the window length to 1 .. MAX_WINDOW.
  logic [CW-1:0] len;
  always_comb begin
    if (wlen_q == '0) begin
      len = CW'(1);
    end else if (32'(wlen_q) > MAX_WINDOW) begin
      len = CW'(MAX_WINDOW);
    end else begin
      len = CW'(wlen_q);
    end
  end

  logic          busy_q, start_q, out_vld_q;
  logic [CW-1:0] fill_q, fill_next;
  logic          in_acc, produce, last_vld, take;
  swca_ctrl_t    ctrl;

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign fill_next  = (fill_q == CW'(MAX_WINDOW)) ? fill_q : fill_q + CW'(1);
  assign produce    = (fill_next >= len);

  // Drop the token into the output register when it is free or being freed;
  // hold the chain otherwise.
  assign take       = last_vld && (!out_vld_q || out_ready_i);
  assign ctrl.adv   = !(last_vld && out_vld_q && !out_ready_i);
  assign ctrl.shift = in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      busy_q    <= 1'b0;
      start_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        fill_q <= fill_next;
      end
      if (in_acc && produce) begin
        busy_q <= 1'b1;
      end else if (take) begin
        busy_q <= 1'b0;
      end
      if (in_acc && produce) begin
        start_q <= 1'b1;
      end else if (ctrl.adv) begin
        start_q <= 1'b0;
      end
      if (take) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the newest close and date while the token walks.
  logic [PRICE_BITS-1:0] close_q;
  logic [DAY_BITS-1:0]   day_q;
  logic [MONTH_BITS-1:0] month_q;
  logic [YEAR_BITS-1:0]  year_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      close_q <= PRICE_BITS'(PW'(close_price_i));
      day_q   <= day_in_i;
      month_q <= month_in_i;
      year_q  <= year_in_i;
    end
  end

  // Cell chain: link 0 feeds the head cell, link MAX_WINDOW leaves the tail.
  logic [PW-1:0] c_opn [MAX_WINDOW+1];
  logic [PW-1:0] c_hi  [MAX_WINDOW+1];
  logic [PW-1:0] c_lo  [MAX_WINDOW+1];
  logic          t_vld [MAX_WINDOW+1];
  logic [CW-1:0] t_rem [MAX_WINDOW+1];
  logic [PW-1:0] t_hi  [MAX_WINDOW+1];
  logic [PW-1:0] t_lo  [MAX_WINDOW+1];
  logic [PW-1:0] t_opn [MAX_WINDOW+1];

  assign c_opn[0] = PW'(open_price_i);
  assign c_hi[0]  = PW'(high_price_i);
  assign c_lo[0]  = PW'(low_price_i);
  // Start the token with identities for max and min.
  assign t_vld[0] = start_q;
  assign t_rem[0] = len;
  assign t_hi[0]  = '0;
  assign t_lo[0]  = '1;
  assign t_opn[0] = '0;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    swca_cell #(
      .PW (PW),
      .CW (CW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .opn_i     (c_opn[k]),
      .hi_i      (c_hi[k]),
      .lo_i      (c_lo[k]),
      .opn_o     (c_opn[k+1]),
      .hi_o      (c_hi[k+1]),
      .lo_o      (c_lo[k+1]),
      .tok_vld_i (t_vld[k]),
      .tok_rem_i (t_rem[k]),
      .tok_hi_i  (t_hi[k]),
      .tok_lo_i  (t_lo[k]),
      .tok_opn_i (t_opn[k]),
      .tok_vld_o (t_vld[k+1]),
      .tok_rem_o (t_rem[k+1]),
      .tok_hi_o  (t_hi[k+1]),
      .tok_lo_o  (t_lo[k+1]),
      .tok_opn_o (t_opn[k+1])
    );
  end

  assign last_vld = t_vld[MAX_WINDOW];

  // Output register.
  logic [PRICE_BITS-1:0] o_opn_q, o_hi_q, o_lo_q, o_cls_q;
  logic [DAY_BITS-1:0]   o_day_q;
  logic [MONTH_BITS-1:0] o_mon_q;
  logic [YEAR_BITS-1:0]  o_yr_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      o_opn_q <= PRICE_BITS'(t_opn[MAX_WINDOW]);
      o_hi_q  <= PRICE_BITS'(t_hi[MAX_WINDOW]);
      o_lo_q  <= PRICE_BITS'(t_lo[MAX_WINDOW]);
      o_cls_q <= close_q;
      o_day_q <= day_q;
      o_mon_q <= month_q;
      o_yr_q  <= year_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign agg_open_o  = o_opn_q;
  assign agg_high_o  = o_hi_q;
  assign agg_low_o   = o_lo_q;
  assign agg_close_o = o_cls_q;
  assign day_out_o   = o_day_q;
  assign month_out_o = o_mon_q;
  assign year_out_o  = o_yr_q;

endmodule

### design/swca_chk.sv
// Port-level checker for the candle aggregator, bound to the top level.
`include "sliding_window_candle_aggregator_unit_assert.svh"

module swca_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [swca_pkg::PRICE_BITS-1:0]  agg_open_o,
  input logic [swca_pkg::PRICE_BITS-1:0]  agg_high_o,
  input logic [swca_pkg::PRICE_BITS-1:0]  agg_low_o,
  input logic [swca_pkg::PRICE_BITS-1:0]  agg_close_o
);
  import swca_pkg::*;

  // A stalled result holds its prices.
  `SWCA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(agg_open_o) && $stable(agg_high_o) && $stable(agg_low_o) && $stable(agg_close_o),
    "stalled result changed")
  // The input closes only after it took a transaction.
  `SWCA_ASSERT_NOW(a_close_on_accept, $fell(in_ready_o), $past(in_valid_i),
    "input closed without a transaction")
  // A new result appears only at the end of a sweep, while the input is closed.
  `SWCA_ASSERT_NOW(a_result_from_sweep, $rose(out_valid_o), !$past(in_ready_o),
    "result appeared without a sweep")
  // The input reopens only when the sweep has landed in the output register.
  `SWCA_ASSERT_NOW(a_reopen_with_result, $rose(in_ready_o), out_valid_o,
    "input reopened without a result")

endmodule

bind sliding_window_candle_aggregator_unit swca_chk u_swca_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .agg_open_o  (agg_open_o),
  .agg_high_o  (agg_high_o),
  .agg_low_o   (agg_low_o),
  .agg_close_o (agg_close_o)
);
